// ===== hdl/sbbm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbbm_pkg
// Shared types and constants of the sample block buffer manager.
// ----------------------------------------------------------------------------
`default_nettype none

package sbbm_pkg;

    // fixed field widths and pool sizes
    localparam int BUFFER_COUNT    = 4;
    localparam int ID_W            = 2;
    localparam int BLOCK_WORDS     = 256;
    localparam int MAX_CHANNELS    = 8;
    localparam int CHAN_W          = 3;
    localparam int CCOUNT_W        = 4;
    localparam int FILL_W          = 9;
    localparam int SLOT_W          = 8;
    localparam int SAMPLE_W        = 10;
    localparam int DROP_W          = 16;
    localparam logic [DROP_W-1:0] DROP_MAX = 16'hFFFF;

    // defaults of the top level parameters
    localparam int RING_DEPTH_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 2;

    // stream widths
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    // event codes on the input stream
    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_DRAIN  = 2'd2,
        OP_STOP   = 2'd3
    } t_op;

    // classified event as it travels through the command queue
    typedef struct packed {
        logic                is_sample;
        logic                is_tick;
        logic                is_drain;
        logic                is_stop;
        logic [SAMPLE_W-1:0] value;
    } t_cmd;

    // configuration seen by the back end
    typedef struct packed {
        logic [CCOUNT_W-1:0] channel_count;
        logic [FILL_W-1:0]   fill_limit;
    } t_cfg;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [1:0]          pad;
        logic [DROP_W-1:0]   drained_overrun;
        logic [FILL_W-1:0]   drained_count;
        logic [ID_W-1:0]     drained_buffer;
        logic                drained_valid;
        logic [DROP_W-1:0]   overrun_count;
        logic                timer_error;
        logic                block_complete;
        logic [CHAN_W-1:0]   next_channel;
        logic [SAMPLE_W-1:0] stored_value;
        logic [SLOT_W-1:0]   slot;
        logic [ID_W-1:0]     buffer_id;
        logic                stored;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/sbbm_front.sv =====
// ----------------------------------------------------------------------------
// sbbm_front
// Input side: takes events from the stream, decodes the event kind and
// prepares the value to store, then pushes the command into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbm_front (
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [sbbm_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  wire logic [sbbm_pkg::S_TUSER_W-1:0]     i_s_tuser,
    input  wire logic                               i_eight_bit,
    input  wire logic                               i_q_full,
    output logic                                    o_q_push,
    output sbbm_pkg::t_cmd                          o_q_cmd
);
    import sbbm_pkg::*;

    logic [SAMPLE_W-1:0] sample;

    // accept whenever the queue has room
    assign o_s_tready = !i_q_full;
    assign o_q_push   = i_s_tvalid && !i_q_full;
    assign sample     = i_s_tdata[SAMPLE_W-1:0];

    // event decode and eight-bit reduction
    always_comb begin
        o_q_cmd       = '0;
        o_q_cmd.value = i_eight_bit ? {2'b00, sample[SAMPLE_W-1:2]} : sample;
        unique case (t_op'(i_s_tuser)) OP_SAMPLE: begin
            o_q_cmd.is_sample = 1'b1;
        end
        OP_TICK: begin
            o_q_cmd.is_tick = 1'b1;
        end
        OP_DRAIN: begin
            o_q_cmd.is_drain = 1'b1;
        end
        OP_STOP: begin
            o_q_cmd.is_stop = 1'b1;
        end
        default: begin
            o_q_cmd.is_stop = 1'b1;
        end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/sbbm_fifo.sv =====
// ----------------------------------------------------------------------------
// sbbm_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbm_fifo #(
    parameter int DEPTH = sbbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  sbbm_pkg::t_cmd      i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_valid,
    output sbbm_pkg::t_cmd      o_data
);
    import sbbm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sbbm_back.sv =====
// ----------------------------------------------------------------------------
// sbbm_back
// Back end: owns the buffer rings, headers and counters, and carries out each
// command as a frame quotient estimate, then the state update.
// ----------------------------------------------------------------------------
`default_nettype none

module sbbm_back #(
    parameter int RING_DEPTH = sbbm_pkg::RING_DEPTH_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  sbbm_pkg::t_cfg      i_cfg,
    input  wire logic           i_cmd_valid,
    input  sbbm_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output sbbm_pkg::t_result   o_res
);
    import sbbm_pkg::*;

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] FREE_HEAD_RST = PTR_W'(BUFFER_COUNT % RING_DEPTH);
    localparam int RECIP_W = 13;
    localparam int PROD_W  = FILL_W + RECIP_W;
    localparam int BASE_W  = FILL_W + CCOUNT_W;

    // floor(4096 / channels), indexed by the effective channel count
    localparam logic [RECIP_W-1:0] RECIP [16] = '{
        13'd4096, 13'd4096, 13'd2048, 13'd1365, 13'd1024, 13'd819, 13'd682, 13'd585,
        13'd512,  13'd512,  13'd512,  13'd512,  13'd512,  13'd512, 13'd512, 13'd512
    };

    typedef enum logic [1:0] {
        S_FETCH = 2'b01,
        S_APPLY = 2'b10
    } t_back_state;

    t_back_state       r_state;
    t_cmd              r_cmd;
    logic [FILL_W-1:0] r_quot;

    // pool state
    logic [ID_W-1:0]   r_free_ring [RING_DEPTH];
    logic [PTR_W-1:0]  r_free_head;
    logic [PTR_W-1:0]  r_free_tail;
    logic [ID_W-1:0]   r_done_ring [RING_DEPTH];
    logic [PTR_W-1:0]  r_done_head;
    logic [PTR_W-1:0]  r_done_tail;
    logic [ID_W-1:0]   r_held;
    logic [FILL_W-1:0] r_fill;
    logic              r_need;
    logic [DROP_W-1:0] r_drop;
    logic [CHAN_W-1:0] r_chan;
    logic              r_tick_pend;
    logic              r_tick_miss;
    logic [FILL_W-1:0] r_hdr_cnt [BUFFER_COUNT];
    logic [DROP_W-1:0] r_hdr_ovr [BUFFER_COUNT];

    logic              r_out_valid;
    t_result           r_out;

    // next values
    logic [PTR_W-1:0]  n_free_head;
    logic [PTR_W-1:0]  n_free_tail;
    logic [PTR_W-1:0]  n_done_head;
    logic [PTR_W-1:0]  n_done_tail;
    logic [ID_W-1:0]   n_held;
    logic [FILL_W-1:0] n_fill;
    logic              n_need;
    logic [DROP_W-1:0] n_drop;
    logic [CHAN_W-1:0] n_chan;
    logic              n_tick_pend;
    logic              n_tick_miss;
    t_result           res;

    // array write ports
    logic              wr_free;
    logic [ID_W-1:0]   wr_free_id;
    logic              wr_done;
    logic [ID_W-1:0]   wr_done_id;
    logic              wr_cnt;
    logic [ID_W-1:0]   wr_cnt_id;
    logic [FILL_W-1:0] wr_cnt_val;
    logic              wr_ovr;
    logic [ID_W-1:0]   wr_ovr_id;

    logic [CCOUNT_W-1:0] eff_ch;
    logic [FILL_W-1:0]   eff_limit;
    logic [PROD_W-1:0]   quot_prod;
    logic [BASE_W-1:0]   frame_base;
    logic [BASE_W-1:0]   frame_rem;
    logic [FILL_W-1:0]   trunc_fill;
    logic                no_free;
    logic [ID_W-1:0]     take_id;
    logic [ID_W-1:0]     buf_id;
    logic [FILL_W-1:0]   fill_base;
    logic [FILL_W-1:0]   fill_inc;
    logic [ID_W-1:0]     drain_id;
    logic                fetch_go;
    logic                apply_go;

    function automatic logic [PTR_W-1:0] f_ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // reset content of one free ring entry: last buffer id that lands there
    function automatic logic [ID_W-1:0] f_free_init(input int slot);
        logic [ID_W-1:0] id;
        id = '0;
        for (int i = 0; i < BUFFER_COUNT; i++) begin
            if ((i % RING_DEPTH) == slot) begin
                id = ID_W'(i);
            end
        end
        return id;
    endfunction

    // clamp the configuration into its working range
    always_comb begin
        if (i_cfg.channel_count == '0) begin
            eff_ch = CCOUNT_W'(1);
        end else if (i_cfg.channel_count > CCOUNT_W'(MAX_CHANNELS)) begin
            eff_ch = CCOUNT_W'(MAX_CHANNELS);
        end else begin
            eff_ch = i_cfg.channel_count;
        end
        if (i_cfg.fill_limit == '0) begin
            eff_limit = FILL_W'(1);
        end else if (i_cfg.fill_limit > FILL_W'(BLOCK_WORDS)) begin
            eff_limit = FILL_W'(BLOCK_WORDS);
        end else begin
            eff_limit = i_cfg.fill_limit;
        end
    end

    // handshakes of the two steps
    assign fetch_go    = (r_state == S_FETCH) && i_cmd_valid;
    assign apply_go    = (r_state == S_APPLY) && (!r_out_valid || i_res_ready);
    assign o_cmd_pop   = fetch_go;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // first step: quotient estimate of fill / channels, at most one low
    assign quot_prod = PROD_W'(r_fill) * PROD_W'(RECIP[eff_ch]);

    // second step: exact whole-frame fill from the estimate
    always_comb begin
        frame_base = BASE_W'(r_quot) * BASE_W'(eff_ch);
        frame_rem  = BASE_W'(r_fill) - frame_base;
        if (frame_rem >= BASE_W'(eff_ch)) begin
            trunc_fill = FILL_W'(frame_base + BASE_W'(eff_ch));
        end else begin
            trunc_fill = FILL_W'(frame_base);
        end
    end

    assign no_free   = r_need && (r_free_head == r_free_tail);
    assign take_id   = r_free_ring[r_free_tail];
    assign buf_id    = r_need ? take_id : r_held;
    assign fill_base = r_need ? '0 : r_fill;
    assign fill_inc  = fill_base + 1'b1;
    assign drain_id  = r_done_ring[r_done_tail];

    // command execution
    always_comb begin
        n_free_head = r_free_head;
        n_free_tail = r_free_tail;
        n_done_head = r_done_head;
        n_done_tail = r_done_tail;
        n_held      = r_held;
        n_fill      = r_fill;
        n_need      = r_need;
        n_drop      = r_drop;
        n_chan      = r_chan;
        n_tick_pend = r_tick_pend;
        n_tick_miss = r_tick_miss;
        res         = '0;
        wr_free     = 1'b0;
        wr_free_id  = drain_id;
        wr_done     = 1'b0;
        wr_done_id  = buf_id;
        wr_cnt      = 1'b0;
        wr_cnt_id   = buf_id;
        wr_cnt_val  = fill_inc;
        wr_ovr      = 1'b0;
        wr_ovr_id   = take_id;

        priority if (r_cmd.is_sample) begin
            if (no_free) begin
                // no buffer to take: drop the sample
                if (r_drop != DROP_MAX) begin
                    n_drop = r_drop + 1'b1;
                end
                n_tick_pend = 1'b0;
            end else begin
                // round-robin channel advance
                if (eff_ch > CCOUNT_W'(1)) begin
                    if (r_chan == '0) begin
                        n_tick_pend = 1'b0;
                    end
                    if ({1'b0, r_chan} >= eff_ch - 1'b1) begin
                        n_chan = '0;
                    end else begin
                        n_chan = r_chan + 1'b1;
                    end
                end else begin
                    n_tick_pend = 1'b0;
                end
                // take a fresh buffer from the free ring
                if (r_need) begin
                    n_held      = take_id;
                    n_free_tail = f_ptr_next(r_free_tail);
                    n_need      = 1'b0;
                    wr_ovr      = 1'b1;
                end
                res.stored       = 1'b1;
                res.buffer_id    = buf_id;
                res.slot         = fill_base[SLOT_W-1:0];
                res.stored_value = r_cmd.value;
                n_fill           = fill_inc;
                // buffer full: push to the done ring
                if (fill_inc >= eff_limit) begin
                    wr_cnt             = 1'b1;
                    wr_done            = 1'b1;
                    n_done_head        = f_ptr_next(r_done_head);
                    n_need             = 1'b1;
                    n_drop             = '0;
                    res.block_complete = 1'b1;
                end
            end
        end else if (r_cmd.is_tick) begin
            if (r_tick_pend) begin
                n_tick_miss = 1'b1;
            end
            n_tick_pend = 1'b1;
        end else if (r_cmd.is_drain) begin
            // oldest full buffer goes back to the free ring
            if (r_done_head != r_done_tail) begin
                n_done_tail         = f_ptr_next(r_done_tail);
                wr_free             = 1'b1;
                n_free_head         = f_ptr_next(r_free_head);
                res.drained_valid   = 1'b1;
                res.drained_buffer  = drain_id;
                res.drained_count   = r_hdr_cnt[drain_id];
                res.drained_overrun = r_hdr_ovr[drain_id];
            end
        end else begin
            // stop: flush the held buffer cut to whole frames
            if (!r_need && (r_fill >= FILL_W'(eff_ch))) begin
                wr_cnt             = 1'b1;
                wr_cnt_id          = r_held;
                wr_cnt_val         = trunc_fill;
                wr_done            = 1'b1;
                wr_done_id         = r_held;
                n_done_head        = f_ptr_next(r_done_head);
                n_need             = 1'b1;
                n_fill             = '0;
                res.block_complete = 1'b1;
            end
        end

        res.next_channel  = n_chan;
        res.timer_error   = n_tick_miss;
        res.overrun_count = n_drop;
    end

    // sequencer, control state and free ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_free_head <= FREE_HEAD_RST;
            r_free_tail <= '0;
            r_done_head <= '0;
            r_done_tail <= '0;
            r_held      <= '0;
            r_fill      <= '0;
            r_need      <= 1'b1;
            r_drop      <= '0;
            r_chan      <= '0;
            r_tick_pend <= 1'b0;
            r_tick_miss <= 1'b0;
            r_out_valid <= 1'b0;
            for (int e = 0; e < RING_DEPTH; e++) begin
                r_free_ring[e] <= f_free_init(e);
            end
        end else begin
            unique case (r_state)
            S_FETCH: begin
                if (fetch_go) begin
                    r_state <= S_APPLY;
                end
            end
            S_APPLY: begin
                if (apply_go) begin
                    r_state <= S_FETCH;
                end
            end
            default: begin
                r_state <= S_FETCH;
            end
            endcase
            if (apply_go) begin
                r_free_head <= n_free_head;
                r_free_tail <= n_free_tail;
                r_done_head <= n_done_head;
                r_done_tail <= n_done_tail;
                r_held      <= n_held;
                r_fill      <= n_fill;
                r_need      <= n_need;
                r_drop      <= n_drop;
                r_chan      <= n_chan;
                r_tick_pend <= n_tick_pend;
                r_tick_miss <= n_tick_miss;
                if (wr_free) begin
                    r_free_ring[r_free_head] <= wr_free_id;
                end
            end
            if (apply_go) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: command, estimate, done ring, headers and result
    always_ff @(posedge i_clk) begin
        if (fetch_go) begin
            r_cmd  <= i_cmd;
            r_quot <= quot_prod[RECIP_W-1 +: FILL_W];
        end
        if (apply_go) begin
            r_out <= res;
            if (wr_done) begin
                r_done_ring[r_done_head] <= wr_done_id;
            end
            if (wr_cnt) begin
                r_hdr_cnt[wr_cnt_id] <= wr_cnt_val;
            end
            if (wr_ovr) begin
                r_hdr_ovr[wr_ovr_id] <= r_drop;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sample_block_buffer_manager_core.sv =====
// ----------------------------------------------------------------------------
// sample_block_buffer_manager_core
// Buffer pool manager for a round-robin ADC logger: event stream in, one
// result per event out, configuration over an APB-style port.
// ----------------------------------------------------------------------------
//
//  channel   | direction | content
//  ----------+-----------+----------------------------------------------------
//  s stream  | in        | tuser: operation; tdata: sample
//  m stream  | out       | tdata: one result per event (see port comment)
//  apb       | in/out    | 0x0 channel_count, 0x4 block_fill_limit,
//            |           | 0x8 eight_bit_mode
//
//  The front end accepts one event per cycle while the queue has room; the
//  queue holds two entries by default. The back end handles each event as a
//  reciprocal multiply for the frame quotient, then the state update with the
//  result registered, and takes no new event before that update is done.
//  A stalled result waits in the output register while the next event is
//  fetched; reset is synchronous and clears all control state.
//
`default_nettype none

module sample_block_buffer_manager_core #(
    parameter int RING_DEPTH  = sbbm_pkg::RING_DEPTH_DEF,
    parameter int QUEUE_DEPTH = sbbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input stream
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    // [9:0] sample, [15:10] zero
    input  wire logic [sbbm_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // [1:0] operation
    input  wire logic [sbbm_pkg::S_TUSER_W-1:0]     i_s_tuser,
    // result stream
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // [0] stored, [2:1] buffer_id, [10:3] slot, [20:11] stored_value,
    // [23:21] next_channel, [24] block_complete, [25] timer_error,
    // [41:26] overrun_count, [42] drained_valid, [44:43] drained_buffer,
    // [53:45] drained_count, [69:54] drained_overrun, [71:70] zero
    output logic [sbbm_pkg::M_TDATA_W-1:0]          o_m_tdata,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [3:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);
    import sbbm_pkg::*;

    localparam logic [1:0] REG_CHANNELS = 2'd0;
    localparam logic [1:0] REG_LIMIT    = 2'd1;
    localparam logic [1:0] REG_MODE     = 2'd2;

    logic [CCOUNT_W-1:0] r_channel_count;
    logic [FILL_W-1:0]   r_fill_limit;
    logic                r_eight_bit;
    logic                cfg_write;
    logic [1:0]          reg_index;

    t_cfg    cfg;
    logic    q_full;
    logic    q_push;
    t_cmd    q_in;
    logic    q_pop;
    logic    q_valid;
    t_cmd    q_out;
    t_result res;

    // configuration registers
    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= CCOUNT_W'(1);
            r_fill_limit    <= FILL_W'(BLOCK_WORDS);
            r_eight_bit     <= 1'b0;
        end else if (cfg_write) begin
            unique case (reg_index)
            REG_CHANNELS: begin
                r_channel_count <= pwdata[CCOUNT_W-1:0];
            end
            REG_LIMIT: begin
                r_fill_limit <= pwdata[FILL_W-1:0];
            end
            REG_MODE: begin
                r_eight_bit <= pwdata[0];
            end
            default: begin
                r_eight_bit <= r_eight_bit;
            end
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (reg_index)
        REG_CHANNELS: begin
            prdata = 32'(r_channel_count);
        end
        REG_LIMIT: begin
            prdata = 32'(r_fill_limit);
        end
        REG_MODE: begin
            prdata = 32'(r_eight_bit);
        end
        default: begin
            prdata = '0;
        end
        endcase
    end

    assign cfg.channel_count = r_channel_count;
    assign cfg.fill_limit    = r_fill_limit;

    // event decode
    sbbm_front u_front (
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_eight_bit (r_eight_bit),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in)
    );

    // command queue
    sbbm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // buffer pool execution
    sbbm_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    assign o_m_tdata = M_TDATA_W'(res);

endmodule

`default_nettype wire

// ===== verif/sbbm_result_checker.sv =====
// ----------------------------------------------------------------------------
// sbbm_result_checker
// Watches the event stream, the result stream and the register port of the
// buffer manager, predicts one result per accepted event from its own model
// of the buffer pool and compares every result field by field.
// ----------------------------------------------------------------------------
module sbbm_result_checker #(
    parameter logic [3:0] REG_CHANNELS   = 4'h0,
    parameter logic [3:0] REG_FILL_LIMIT = 4'h4,
    parameter logic [3:0] REG_EIGHT_BIT  = 4'h8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // event stream
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [sbbm_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [sbbm_pkg::S_TUSER_W-1:0] i_s_tuser,
    // result stream
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [sbbm_pkg::M_TDATA_W-1:0] i_m_tdata,
    // register port
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [3:0]                     i_paddr,
    input  logic [31:0]                    i_pwdata,
    input  logic                           i_pready,
    // status for the test top
    output int                             o_failures,
    output int                             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import sbbm_pkg::*;

    localparam int RING_SLOTS   = RING_DEPTH_DEF;
    localparam int RING_W       = $clog2(RING_SLOTS);
    localparam int REPORT_LIMIT = 10;

    // register copies
    logic [CCOUNT_W-1:0] cfg_channels;
    logic [FILL_W-1:0]   cfg_limit;
    logic                cfg_eight_bit;

    // buffer pool model
    logic [ID_W-1:0]   free_ids [RING_SLOTS];
    logic [RING_W-1:0] free_wr;
    logic [RING_W-1:0] free_rd;
    logic [ID_W-1:0]   full_ids [RING_SLOTS];
    logic [RING_W-1:0] full_wr;
    logic [RING_W-1:0] full_rd;
    logic [ID_W-1:0]   held_id;
    logic [FILL_W-1:0] fill_count;
    logic              wants_buffer;
    logic [DROP_W-1:0] drop_count;
    logic [CHAN_W-1:0] chan_next;
    logic              tick_armed;
    logic              tick_late;
    logic [FILL_W-1:0] hdr_fill  [BUFFER_COUNT];
    logic [DROP_W-1:0] hdr_drops [BUFFER_COUNT];

    t_result results_due [$];
    int      failures = 0;

    function automatic logic [RING_W-1:0] ring_next(input logic [RING_W-1:0] ptr);
        return (ptr == RING_W'(RING_SLOTS - 1)) ? '0 : ptr + 1'b1;
    endfunction

    // hand the held buffer over to the full queue
    function automatic void close_block();
        hdr_fill[held_id] = fill_count;
        full_ids[full_wr] = held_id;
        full_wr = ring_next(full_wr);
        wants_buffer = 1'b1;
    endfunction

    // advance the pool by one event and return the result it produces
    function automatic t_result pool_step(input t_op op, input logic [SAMPLE_W-1:0] value);
        t_result         r;
        int unsigned     nch;
        int unsigned     lim;
        logic [ID_W-1:0] b;
        r = '0;
        nch = (cfg_channels == 0) ? 1 :
              (cfg_channels > MAX_CHANNELS) ? MAX_CHANNELS : cfg_channels;
        lim = (cfg_limit == 0) ? 1 :
              (cfg_limit > BLOCK_WORDS) ? BLOCK_WORDS : cfg_limit;
        case (op)
            OP_SAMPLE: begin
                if (wants_buffer && free_wr == free_rd) begin
                    // pool exhausted: drop the sample, saturating count
                    if (drop_count != DROP_MAX) drop_count = drop_count + 1'b1;
                    tick_armed = 1'b0;
                end else begin
                    // round robin channel, tick served on channel 0
                    if (nch > 1) begin
                        if (chan_next == 0) tick_armed = 1'b0;
                        chan_next = (chan_next >= nch - 1) ? '0 : chan_next + 1'b1;
                    end else begin
                        tick_armed = 1'b0;
                    end
                    if (wants_buffer) begin
                        held_id = free_ids[free_rd];
                        free_rd = ring_next(free_rd);
                        fill_count = '0;
                        hdr_drops[held_id] = drop_count;
                        wants_buffer = 1'b0;
                    end
                    r.stored       = 1'b1;
                    r.buffer_id    = held_id;
                    r.slot         = fill_count[SLOT_W-1:0];
                    r.stored_value = cfg_eight_bit ? {2'b00, value[SAMPLE_W-1:2]} : value;
                    fill_count = fill_count + 1'b1;
                    if (fill_count >= lim) begin
                        close_block();
                        drop_count = '0;
                        r.block_complete = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (tick_armed) tick_late = 1'b1;
                tick_armed = 1'b1;
            end
            OP_DRAIN: begin
                if (full_wr != full_rd) begin
                    b = full_ids[full_rd];
                    full_rd = ring_next(full_rd);
                    free_ids[free_wr] = b;
                    free_wr = ring_next(free_wr);
                    r.drained_valid   = 1'b1;
                    r.drained_buffer  = b;
                    r.drained_count   = hdr_fill[b];
                    r.drained_overrun = hdr_drops[b];
                end
            end
            OP_STOP: begin
                // flush whole frames only
                if (!wants_buffer && fill_count >= nch) begin
                    fill_count = FILL_W'(nch * (fill_count / nch));
                    close_block();
                    fill_count = '0;
                    r.block_complete = 1'b1;
                end
            end
        endcase
        r.next_channel  = chan_next;
        r.timer_error   = tick_late;
        r.overrun_count = drop_count;
        return r;
    endfunction

    task automatic show_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
        if (want_v !== got_v)
            $display("  %s: expected %0d, got %0d", name, want_v, got_v);
    endtask

    // channel monitor, predictor and compare
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            cfg_channels  = CCOUNT_W'(1);
            cfg_limit     = FILL_W'(BLOCK_WORDS);
            cfg_eight_bit = 1'b0;
            for (int i = 0; i < RING_SLOTS; i++) begin
                free_ids[i] = '0;
                full_ids[i] = '0;
            end
            for (int i = 0; i < BUFFER_COUNT; i++) begin
                free_ids[i]  = ID_W'(i);
                hdr_fill[i]  = '0;
                hdr_drops[i] = '0;
            end
            free_wr      = RING_W'(BUFFER_COUNT % RING_SLOTS);
            free_rd      = '0;
            full_wr      = '0;
            full_rd      = '0;
            held_id      = '0;
            fill_count   = '0;
            wants_buffer = 1'b1;
            drop_count   = '0;
            chan_next    = '0;
            tick_armed   = 1'b0;
            tick_late    = 1'b0;
            results_due.delete();
        end else begin
            // register write transfer
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    REG_CHANNELS:   cfg_channels  = i_pwdata[CCOUNT_W-1:0];
                    REG_FILL_LIMIT: cfg_limit     = i_pwdata[FILL_W-1:0];
                    REG_EIGHT_BIT:  cfg_eight_bit = i_pwdata[0];
                    default: ;
                endcase
            end
            // event transfer
            if (i_s_tvalid && i_s_tready)
                results_due.push_back(pool_step(t_op'(i_s_tuser), i_s_tdata[SAMPLE_W-1:0]));
            // result transfer
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata;
                if (results_due.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected result at %0t: %h", $time, got);
                end else begin
                    want = results_due.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= REPORT_LIMIT) begin
                            $display("mismatch at %0t: expected %h, got %h", $time, want, got);
                            show_field("stored", want.stored, got.stored);
                            show_field("buffer_id", want.buffer_id, got.buffer_id);
                            show_field("slot", want.slot, got.slot);
                            show_field("stored_value", want.stored_value, got.stored_value);
                            show_field("next_channel", want.next_channel, got.next_channel);
                            show_field("block_complete", want.block_complete,
                                       got.block_complete);
                            show_field("timer_error", want.timer_error, got.timer_error);
                            show_field("overrun_count", want.overrun_count,
                                       got.overrun_count);
                            show_field("drained_valid", want.drained_valid,
                                       got.drained_valid);
                            show_field("drained_buffer", want.drained_buffer,
                                       got.drained_buffer);
                            show_field("drained_count", want.drained_count,
                                       got.drained_count);
                            show_field("drained_overrun", want.drained_overrun,
                                       got.drained_overrun);
                            show_field("pad", want.pad, got.pad);
                        end
                    end
                end
            end
        end
        o_failures    <= failures;
        o_outstanding <= results_due.size();
    end

endmodule

// ===== verif/tb_sample_block_buffer_manager_core.sv =====
// ----------------------------------------------------------------------------
// tb_sample_block_buffer_manager_core
// Drives events and register writes into the buffer manager under random
// back-pressure; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_sample_block_buffer_manager_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sbbm_pkg::*;

    localparam logic [3:0] REG_CHANNELS   = 4'h0;
    localparam logic [3:0] REG_FILL_LIMIT = 4'h4;
    localparam logic [3:0] REG_EIGHT_BIT  = 4'h8;

    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 16;
    localparam int CYCLE_LIMIT     = 2000000;
    localparam int RANDOM_CHUNKS   = 12;
    localparam int CHUNK_ITEMS     = 135;
    localparam int OVERRUN_SAMPLES = 40;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [3:0]           paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    int send_idle_pct = 9;
    int recv_idle_pct = 49;
    int cycle_count   = 0;
    int failures;
    int outstanding;

    sample_block_buffer_manager_core uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    sbbm_result_checker #(
        .REG_CHANNELS   (REG_CHANNELS),
        .REG_FILL_LIMIT (REG_FILL_LIMIT),
        .REG_EIGHT_BIT  (REG_EIGHT_BIT)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    // clock
    always #6 clk = ~clk;

    // result side back-pressure
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // run watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one event transfer, with idle cycles ahead of it at the sender rate
    task automatic send_event(input t_op op, input logic [SAMPLE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, value};
        do @(posedge clk); while (!s_tready);
    endtask

    // stop sending and let every pending result come out
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only with the block idle
    task automatic configure(input logic [CCOUNT_W-1:0] channels,
                             input logic [FILL_W-1:0] fill_limit,
                             input logic eight_bit);
        wait_all_results();
        apb_write(REG_CHANNELS, {{(32 - CCOUNT_W){1'b0}}, channels});
        apb_write(REG_FILL_LIMIT, {{(32 - FILL_W){1'b0}}, fill_limit});
        apb_write(REG_EIGHT_BIT, {31'd0, eight_bit});
    endtask

    initial begin
        int                  chunk;
        int                  k;
        int                  pick;
        int                  ch;
        int                  lim;
        logic                eight;
        logic [SAMPLE_W-1:0] value;
        t_op                 op;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed: three channels, short blocks, eight-bit samples
        configure(4'd3, 9'd8, 1'b1);
        send_event(OP_DRAIN, 10'h000);      // nothing full yet
        send_event(OP_STOP, 10'h000);       // no buffer held
        send_event(OP_TICK, 10'h000);
        send_event(OP_TICK, 10'h000);       // tick before any sample
        send_event(OP_SAMPLE, 10'h3FF);
        send_event(OP_SAMPLE, 10'h000);
        send_event(OP_SAMPLE, 10'h155);
        send_event(OP_STOP, 10'h000);       // exactly one frame flushed
        send_event(OP_SAMPLE, 10'h2AA);
        send_event(OP_STOP, 10'h000);       // fewer samples than channels
        for (k = 0; k < 4; k++) send_event(OP_SAMPLE, SAMPLE_W'(10'h200 + k));
        send_event(OP_STOP, 10'h000);       // partial frame cut off

        // directed: zero registers act as one channel, one-sample blocks
        configure(4'd0, 9'd0, 1'b0);
        send_event(OP_SAMPLE, 10'h3FF);
        send_event(OP_SAMPLE, 10'h001);
        send_event(OP_SAMPLE, 10'h0F0);     // pool exhausted, dropped
        send_event(OP_SAMPLE, 10'h00F);
        send_event(OP_DRAIN, 10'h000);
        send_event(OP_SAMPLE, 10'h123);     // header records the drops
        for (k = 0; k < 4; k++) send_event(OP_DRAIN, 10'h000);

        // random chunks over several register settings and idle patterns
        for (chunk = 0; chunk < RANDOM_CHUNKS; chunk++) begin
            if (chunk == RANDOM_CHUNKS / 3) begin
                send_idle_pct = 49;
                recv_idle_pct = 9;
            end else if (chunk == 2 * RANDOM_CHUNKS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (chunk)
                0: configure(4'd8, 9'd256, 1'b0);
                1: configure(4'd1, 9'd1, 1'b1);
                2: configure(4'd15, 9'd511, 1'b1);
                default: begin
                    pick = $urandom_range(99);
                    ch = (pick < 80) ? $urandom_range(1, MAX_CHANNELS) : $urandom_range(0, 15);
                    pick = $urandom_range(99);
                    if (pick < 60)      lim = $urandom_range(1, 12);
                    else if (pick < 75) lim = $urandom_range(13, 255);
                    else if (pick < 85) lim = BLOCK_WORDS;
                    else                lim = $urandom_range(0, 511);
                    eight = 1'($urandom_range(1));
                    configure(ch[CCOUNT_W-1:0], lim[FILL_W-1:0], eight);
                end
            endcase
            for (k = 0; k < CHUNK_ITEMS; k++) begin
                pick = $urandom_range(99);
                if (pick < 60)      op = OP_SAMPLE;
                else if (pick < 80) op = OP_DRAIN;
                else if (pick < 90) op = OP_TICK;
                else                op = OP_STOP;
                case ($urandom_range(9))
                    0:       value = '0;
                    1:       value = '1;
                    default: value = SAMPLE_W'($urandom_range(1023));
                endcase
                send_event(op, value);
            end
        end

        // overrun counting with every buffer full
        configure(4'd2, 9'd1, 1'b0);
        for (k = 0; k < OVERRUN_SAMPLES; k++) begin
            value = SAMPLE_W'($urandom_range(1023));
            send_event(OP_SAMPLE, value);
        end
        for (k = 0; k < 5; k++) send_event(OP_DRAIN, 10'h000);
        for (k = 0; k < 3; k++) send_event(OP_SAMPLE, 10'h3C3);
        send_event(OP_DRAIN, 10'h000);

        wait_all_results();
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sample_block_buffer_manager_core.f =====
hdl/sbbm_pkg.sv
hdl/sbbm_front.sv
hdl/sbbm_fifo.sv
hdl/sbbm_back.sv
hdl/sample_block_buffer_manager_core.sv
verif/sbbm_result_checker.sv
verif/tb_sample_block_buffer_manager_core.sv
